// File: design/sist_pkg.sv
package sist_pkg;

    typedef struct packed {
        logic [1:0]  action;
        logic [9:0]  vertex;
        logic [7:0]  bone;
        logic [15:0] weight;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  slot_number;
        logic        slot_used;
        logic [7:0]  slot_bone;
        logic [15:0] slot_weight;
        logic [15:0] discarded_weight;
        logic        last;
    } t_out_item;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_NORM = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd3;

    localparam logic [2:0] ST_FILLED = 3'd0;
    localparam logic [2:0] ST_REPLACED = 3'd1;
    localparam logic [2:0] ST_DISCARDED = 3'd2;
    localparam logic [2:0] ST_BELOW = 3'd3;
    localparam logic [2:0] ST_CLEARED = 3'd4;
    localparam logic [2:0] ST_NORMALIZED = 3'd5;
    localparam logic [2:0] ST_TOO_SMALL = 3'd6;

    localparam logic [0:0] CFG_INSERT_THR = 1'd0;
    localparam logic [0:0] CFG_NORM_THR = 1'd1;

    localparam logic [15:0] ONE_Q15 = 16'h8000;

endpackage

// File: design/sist_div.sv
// restoring divider: quotient of (num << 15) / den, one bit per cycle
module sist_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_num,
    input  logic [17:0] i_den,
    output logic        o_done,
    output logic [15:0] o_quot
);
    // 31-bit dividend, quotient kept to 16 bits (num <= total so q <= 32768)
    logic [30:0] r_dvd;
    logic [18:0] r_rem;
    logic [17:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [15:0] r_quot;
    logic        r_done;
    logic [18:0] w_trial;
    logic [19:0] w_diff;

    assign w_trial = {r_rem[17:0], r_dvd[30]};
    assign w_diff = {1'b0, w_trial} - {2'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_dvd <= {i_num, 15'd0};
                r_rem <= '0;
                r_den <= i_den;
                r_cnt <= 5'd0;
                r_quot <= '0;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[29:0], 1'b0};
                if (!w_diff[19]) begin
                    r_rem <= w_diff[18:0];
                    r_quot <= {r_quot[14:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_quot <= {r_quot[14:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd30) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// File: design/skin_influence_slot_table_top.sv
// insert: S_READ, then S_DECIDE posts the result, or S_WRITE posts it when the slot word is written
// normalize: S_READ and S_DECIDE, then per slot S_DIV, S_DIVWAIT for the 31-step division when
//   scaling an occupied slot, and S_EMIT, which waits while a result is still held
// clear: walks all VERTEX_COUNT slot words, one per cycle; the result is posted when the walk ends
// an item is taken only when the block is idle and its result register is empty
// synchronous active-low reset sets thresholds to 1 and runs the same clearing walk, posting no result
module skin_influence_slot_table_top #(
    parameter int VERTEX_COUNT = 1024,
    parameter int SLOTS_PER_VERTEX = 4,
    parameter int BONE_COUNT = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  sist_pkg::t_in_item   i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output sist_pkg::t_out_item  o_item,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);
    localparam int VW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam int SW = (SLOTS_PER_VERTEX > 1) ? $clog2(SLOTS_PER_VERTEX) : 1;

    typedef struct packed {
        logic          used;
        logic [7:0]    bone;
        logic [15:0]   weight;
    } t_slot;

    typedef t_slot [SLOTS_PER_VERTEX-1:0] t_word;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_DECIDE, S_SUM, S_DIV, S_DIVWAIT, S_EMIT, S_WRITE, S_CLEAR
    } t_state;

    // slot memory: one word per vertex
    t_word r_mem [VERTEX_COUNT];
    t_word r_rd;
    t_word r_wk;
    logic  r_we;

    t_state r_state;
    logic [VW-1:0] r_clr_addr;
    logic r_clr_report;
    logic [15:0] r_ins_thr, r_norm_thr;
    logic [VW-1:0] r_vtx;
    logic [7:0] r_bone;
    logic [15:0] r_w;
    logic [1:0] r_act;
    logic [SW-1:0] r_idx;
    logic [17:0] r_total;
    logic r_scale;
    logic r_ovalid;
    sist_pkg::t_out_item r_out;
    logic r_div_start;
    logic div_done;
    logic [15:0] div_quot;

    logic [15:0] w_sat;
    logic [VW-1:0] w_vtx;
    assign w_sat = (i_item.weight > sist_pkg::ONE_Q15) ? sist_pkg::ONE_Q15 : i_item.weight;
    assign w_vtx = VW'(32'(i_item.vertex) % VERTEX_COUNT);

    // memory port: clearing walk or write-back, one read per cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) r_mem[r_clr_addr] <= '0;
        else if (r_we) r_mem[r_vtx] <= r_wk;
        r_rd <= r_mem[(r_state == S_IDLE) ? w_vtx : r_vtx];
    end

    sist_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_start),
        .i_num(r_wk[r_idx].weight), .i_den(r_total),
        .o_done(div_done), .o_quot(div_quot)
    );

    // insert decision over the slot word
    logic w_found_empty;
    logic [SW-1:0] w_empty_idx, w_min_idx;
    logic [15:0] w_min;
    logic w_min_found;
    logic [17:0] w_sum;
    always_comb begin
        w_found_empty = 1'b0;
        w_empty_idx = '0;
        w_min = r_w;
        w_min_idx = '0;
        w_min_found = 1'b0;
        w_sum = '0;
        for (int b = SLOTS_PER_VERTEX - 1; b >= 0; b--) begin
            if (!r_rd[b].used) begin
                w_found_empty = 1'b1;
                w_empty_idx = SW'(b);
            end
        end
        for (int b = 0; b < SLOTS_PER_VERTEX; b++) begin
            if (r_rd[b].used) begin
                w_sum = w_sum + 18'(r_rd[b].weight);
                if (w_min > r_rd[b].weight) begin
                    w_min = r_rd[b].weight;
                    w_min_idx = SW'(b);
                    w_min_found = 1'b1;
                end
            end
        end
    end

    // slot word with the new influence placed
    logic [SW-1:0] w_slot_idx;
    t_word w_new_word;
    assign w_slot_idx = w_found_empty ? w_empty_idx : w_min_idx;
    always_comb begin
        w_new_word = r_rd;
        w_new_word[w_slot_idx] = t_slot'{used: 1'b1, bone: r_bone, weight: r_w};
    end

    logic w_occ;
    assign w_occ = r_wk[r_idx].used;
    assign o_ready = (r_state == S_IDLE) && !r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr_addr <= '0;
            r_clr_report <= 1'b0;
            r_ins_thr <= 16'd1;
            r_norm_thr <= 16'd1;
            r_ovalid <= 1'b0;
            r_we <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_we <= 1'b0;
            r_div_start <= 1'b0;
            if (r_ovalid && i_ready && r_state != S_EMIT) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == sist_pkg::CFG_INSERT_THR) r_ins_thr <= i_cfg_data;
                else r_norm_thr <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_act <= i_item.action;
                        r_vtx <= w_vtx;
                        r_bone <= 8'(32'(i_item.bone) % BONE_COUNT);
                        r_w <= w_sat;
                        r_out <= '{status: 3'd0, slot_number: 2'd0, slot_used: 1'b0,
                                   slot_bone: 8'd0, slot_weight: 16'd0,
                                   discarded_weight: 16'd0, last: 1'b1};
                        if (i_item.action == sist_pkg::ACT_CLEAR) begin
                            r_clr_addr <= '0;
                            r_clr_report <= 1'b1;
                            r_state <= S_CLEAR;
                        end else if (i_item.action == sist_pkg::ACT_INSERT
                                     || i_item.action == sist_pkg::ACT_NORM) begin
                            r_state <= S_READ;
                        end
                    end
                end
                // empty every slot word, one address per cycle
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + VW'(1);
                    if (r_clr_addr == VW'(VERTEX_COUNT - 1)) begin
                        r_state <= S_IDLE;
                        if (r_clr_report) begin
                            r_out.status <= sist_pkg::ST_CLEARED;
                            r_ovalid <= 1'b1;
                        end
                    end
                end
                S_READ: r_state <= S_DECIDE;
                S_DECIDE: begin
                    r_total <= w_sum;
                    r_idx <= '0;
                    if (r_act == sist_pkg::ACT_NORM) begin
                        r_wk <= r_rd;
                        r_scale <= (w_sum != 18'd0) && (w_sum >= 18'(r_norm_thr));
                        r_state <= S_DIV;
                    end else if (r_w < r_ins_thr) begin
                        r_out.status <= sist_pkg::ST_BELOW;
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (w_found_empty || w_min_found) begin
                        r_wk <= w_new_word;
                        r_out.status <= w_found_empty ? sist_pkg::ST_FILLED
                                                      : sist_pkg::ST_REPLACED;
                        r_out.slot_number <= 2'(w_slot_idx);
                        r_out.slot_used <= 1'b1;
                        r_out.slot_bone <= r_bone;
                        r_out.slot_weight <= r_w;
                        r_out.discarded_weight <= w_found_empty ? 16'd0 : w_min;
                        r_state <= S_WRITE;
                        r_we <= 1'b1;
                    end else begin
                        r_out.status <= sist_pkg::ST_DISCARDED;
                        r_out.discarded_weight <= r_w;
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_WRITE: begin
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_DIV: begin
                    if (r_scale && w_occ) begin
                        r_div_start <= 1'b1;
                        r_state <= S_DIVWAIT;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_DIVWAIT: begin
                    if (div_done) begin
                        r_wk[r_idx].weight <= div_quot;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_ovalid || i_ready) begin
                        r_out.status <= r_scale ? sist_pkg::ST_NORMALIZED
                                                : sist_pkg::ST_TOO_SMALL;
                        r_out.slot_number <= 2'(r_idx);
                        r_out.slot_used <= w_occ;
                        r_out.slot_bone <= w_occ ? r_wk[r_idx].bone : 8'd0;
                        r_out.slot_weight <= w_occ ? r_wk[r_idx].weight : 16'd0;
                        r_out.discarded_weight <= 16'd0;
                        r_out.last <= (32'(r_idx) == SLOTS_PER_VERTEX - 1);
                        r_ovalid <= 1'b1;
                        if (32'(r_idx) == SLOTS_PER_VERTEX - 1) begin
                            r_we <= r_scale;
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + SW'(1);
                            r_state <= S_DIV;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_item = r_out;
endmodule

// File: bench/sist_checker.sv
module sist_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_ready_in,
    input  sist_pkg::t_in_item   i_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  sist_pkg::t_out_item  i_out_item,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    output int                   o_errors,
    output int                   o_pending
);
    localparam int SLOTS = 4;
    localparam int DEPTH = 1024 * SLOTS;

    logic        occ_mirror [DEPTH];
    logic [7:0]  bone_mirror [DEPTH];
    logic [15:0] weight_mirror [DEPTH];
    logic [15:0] ins_thr;
    logic [15:0] norm_thr;
    sist_pkg::t_out_item expected_results [$];

    // compute the results of one accepted item and update the mirror
    function automatic void predict_item(sist_pkg::t_in_item it);
        sist_pkg::t_out_item r;
        int base;
        int minidx;
        logic [15:0] w;
        logic [15:0] wmin;
        logic [31:0] total;
        logic [47:0] q;
        logic scale;
        base = int'(it.vertex) * SLOTS;
        w = (it.weight > sist_pkg::ONE_Q15) ? sist_pkg::ONE_Q15 : it.weight;
        r = '0;
        r.last = 1'b1;
        case (it.action)
            sist_pkg::ACT_CLEAR: begin
                for (int i = 0; i < DEPTH; i++) occ_mirror[i] = 1'b0;
                r.status = sist_pkg::ST_CLEARED;
                expected_results.push_back(r);
            end
            sist_pkg::ACT_INSERT: begin
                if (w < ins_thr) begin
                    r.status = sist_pkg::ST_BELOW;
                    expected_results.push_back(r);
                    return;
                end
                wmin = w;
                minidx = -1;
                for (int b = 0; b < SLOTS; b++) begin
                    if (!occ_mirror[base + b]) begin
                        occ_mirror[base + b] = 1'b1;
                        bone_mirror[base + b] = it.bone;
                        weight_mirror[base + b] = w;
                        r.status = sist_pkg::ST_FILLED;
                        r.slot_number = b[1:0];
                        r.slot_used = 1'b1;
                        r.slot_bone = it.bone;
                        r.slot_weight = w;
                        expected_results.push_back(r);
                        return;
                    end
                    if (wmin > weight_mirror[base + b]) begin
                        wmin = weight_mirror[base + b];
                        minidx = b;
                    end
                end
                if (minidx >= 0) begin
                    bone_mirror[base + minidx] = it.bone;
                    weight_mirror[base + minidx] = w;
                    r.status = sist_pkg::ST_REPLACED;
                    r.slot_number = minidx[1:0];
                    r.slot_used = 1'b1;
                    r.slot_bone = it.bone;
                    r.slot_weight = w;
                    r.discarded_weight = wmin;
                end else begin
                    r.status = sist_pkg::ST_DISCARDED;
                    r.discarded_weight = w;
                end
                expected_results.push_back(r);
            end
            sist_pkg::ACT_NORM: begin
                total = '0;
                for (int b = 0; b < SLOTS; b++)
                    if (occ_mirror[base + b]) total += 32'(weight_mirror[base + b]);
                scale = (total != 0) && (total >= 32'(norm_thr));
                for (int b = 0; b < SLOTS; b++) begin
                    r = '0;
                    r.status = scale ? sist_pkg::ST_NORMALIZED : sist_pkg::ST_TOO_SMALL;
                    r.slot_number = b[1:0];
                    r.last = (b == SLOTS - 1);
                    if (occ_mirror[base + b]) begin
                        if (scale) begin
                            q = (48'(weight_mirror[base + b]) * 48'd32768) / 48'(total);
                            weight_mirror[base + b] = q[15:0];
                        end
                        r.slot_used = 1'b1;
                        r.slot_bone = bone_mirror[base + b];
                        r.slot_weight = weight_mirror[base + b];
                    end
                    expected_results.push_back(r);
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) occ_mirror[i] = 1'b0;
            ins_thr <= 16'd1;
            norm_thr <= 16'd1;
            o_errors <= 0;
            expected_results.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                if (i_cfg_index == sist_pkg::CFG_INSERT_THR) ins_thr <= i_cfg_data;
                else norm_thr <= i_cfg_data;
            end
            // compare a leaving item with the oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, i_out_item);
                    o_errors <= o_errors + 1;
                end else begin
                    sist_pkg::t_out_item e;
                    e = expected_results.pop_front();
                    if (e !== i_out_item) begin
                        $display("%0t: mismatch expected %p actual %p",
                                 $time, e, i_out_item);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_valid && i_ready_in) predict_item(i_item);
        end
    end

    assign o_pending = expected_results.size();
endmodule

// File: bench/tb.sv
module tb;
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    sist_pkg::t_in_item  in_item;
    logic        out_valid;
    logic        out_ready;
    sist_pkg::t_out_item out_item;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;
    int          errors;
    int          pending;
    int          idle_cycles;
    bit          hold_off;
    bit          sending;

    skin_influence_slot_table_top uut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_ready(in_ready),
        .i_item(in_item), .o_valid(out_valid), .i_ready(out_ready), .o_item(out_item),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    sist_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_ready_in(in_ready),
        .i_item(in_item), .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_out_item(out_item), .i_cfg_we(cfg_we), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // send one item, waiting for acceptance
    task automatic send_item(logic [1:0] act, logic [9:0] vtx, logic [7:0] bn,
                             logic [15:0] w);
        int g;
        g = sending ? gap_len() : 0;
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= '{action: act, vertex: vtx, bone: bn, weight: w};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // random weight biased toward edges and saturation
    function automatic logic [15:0] rand_weight();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 16));
            1: return 16'($urandom_range(32760, 32768));
            2: return 16'($urandom());
            default: return 16'($urandom_range(0, 16384));
        endcase
    endfunction

    task automatic random_phase(int n);
        logic [9:0] vtx;
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            vtx = 10'($urandom_range(0, 7));
            if ($urandom_range(0, 9) == 0) vtx = 10'($urandom());
            if (r < 2)
                send_item(sist_pkg::ACT_CLEAR, 10'($urandom()), 8'($urandom()),
                          16'($urandom()));
            else if (r < 4)
                send_item(sist_pkg::ACT_NONE, 10'($urandom()), 8'($urandom()),
                          16'($urandom()));
            else if (r < 75) send_item(sist_pkg::ACT_INSERT, vtx, 8'($urandom()), rand_weight());
            else send_item(sist_pkg::ACT_NORM, vtx, 8'($urandom()), 16'($urandom()));
        end
    endtask

    // receiver side stalls
    initial begin
        bit held;
        held = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_off && !held) begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                held = 1'b1;
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            if ($urandom_range(0, 1)) begin
                out_ready <= 1'b0;
                repeat (gap_len() + 1) @(posedge clk);
            end
        end
    end

    // watchdog on handshakes
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles > 20000) begin
                $display("[skin_influence_slot_table_top] ERROR");
                $finish;
            end
        end
    end

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_off = 1'b0;
        sending = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: fill, replace, discard, below threshold, saturation, last vertex, normalize, none, clear
        send_item(sist_pkg::ACT_NORM, 10'd5, 8'd0, 16'd0);
        send_item(sist_pkg::ACT_INSERT, 10'd0, 8'd0, 16'd0);
        send_item(sist_pkg::ACT_INSERT, 10'd0, 8'd255, 16'hFFFF);
        send_item(sist_pkg::ACT_INSERT, 10'd0, 8'd1, 16'd100);
        send_item(sist_pkg::ACT_INSERT, 10'd0, 8'd2, 16'd100);
        send_item(sist_pkg::ACT_INSERT, 10'd0, 8'd3, 16'd50);
        send_item(sist_pkg::ACT_INSERT, 10'd0, 8'd4, 16'd50);
        send_item(sist_pkg::ACT_INSERT, 10'd0, 8'd5, 16'd101);
        send_item(sist_pkg::ACT_INSERT, 10'd0, 8'd6, 16'd1);
        send_item(sist_pkg::ACT_NORM, 10'd0, 8'd0, 16'd0);
        send_item(sist_pkg::ACT_INSERT, 10'd1023, 8'hAA, 16'h5555);
        send_item(sist_pkg::ACT_INSERT, 10'd1023, 8'h55, 16'h2AAA);
        send_item(sist_pkg::ACT_NORM, 10'd1023, 8'd0, 16'd0);
        send_item(sist_pkg::ACT_NONE, 10'd0, 8'd0, 16'd0);
        send_item(sist_pkg::ACT_CLEAR, 10'd0, 8'd0, 16'd0);
        send_item(sist_pkg::ACT_NORM, 10'd0, 8'd0, 16'd0);

        // zero threshold and zero total
        write_reg(sist_pkg::CFG_INSERT_THR, 16'd0);
        write_reg(sist_pkg::CFG_NORM_THR, 16'd0);
        send_item(sist_pkg::ACT_INSERT, 10'd9, 8'd7, 16'd0);
        send_item(sist_pkg::ACT_NORM, 10'd9, 8'd0, 16'd0);

        sending = 1'b1;
        random_phase(80);

        // receiver holds off while items keep coming
        hold_off = 1'b1;
        random_phase(40);

        write_reg(sist_pkg::CFG_INSERT_THR, 16'd32768);
        write_reg(sist_pkg::CFG_NORM_THR, 16'd32768);
        random_phase(60);
        write_reg(sist_pkg::CFG_INSERT_THR, 16'hFFFF);
        write_reg(sist_pkg::CFG_NORM_THR, 16'hFFFF);
        random_phase(30);
        write_reg(sist_pkg::CFG_INSERT_THR, 16'd200);
        write_reg(sist_pkg::CFG_NORM_THR, 16'd20000);
        random_phase(100);
        write_reg(sist_pkg::CFG_INSERT_THR, 16'd1);
        write_reg(sist_pkg::CFG_NORM_THR, 16'd1);
        random_phase(120);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0) $display("[skin_influence_slot_table_top] OK");
        else $display("[skin_influence_slot_table_top] ERROR");
        $finish;
    end
endmodule

// File: files.f
design/sist_pkg.sv
design/sist_div.sv
design/skin_influence_slot_table_top.sv
bench/sist_checker.sv
bench/tb.sv
